### hw/rtl/histogram_equalization_8bit_assert.svh
// Assertion macros for the histogram equalization block.
// Included by histogram_equalization_8bit to check its own logic; no other dependencies.
`ifndef HISTOGRAM_EQUALIZATION_8BIT_ASSERT_SVH
`define HISTOGRAM_EQUALIZATION_8BIT_ASSERT_SVH
`ifndef SYNTHESIS
// Checked on every rising edge of clk_i outside of reset.
`define HE8_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every rising edge of clk_i, reset included.
`define HE8_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define HE8_ASSERT(name, prop, msg)
`define HE8_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

### hw/rtl/he8_pkg.sv
// Shared constants for the histogram equalization block.
// Used by the stream interfaces and the top level; depends on nothing.
package he8_pkg;

  parameter int unsigned BINS       = 256;
  parameter int unsigned PIX_W      = 8;
  parameter int unsigned MAX_PIXELS = 1048576;
  // Counts and the pixel total must hold MAX_PIXELS itself.
  parameter int unsigned CNT_W      = $clog2(MAX_PIXELS + 1);
  // Holds 255 times a running count.
  parameter int unsigned REM_W      = CNT_W + PIX_W;
  parameter int unsigned STEP_W     = $clog2(PIX_W);

endpackage

### hw/rtl/he8_pix_if.sv
// Request channel carrying one gray pixel and its pass information.
// Depends on he8_pkg for the pixel width.
interface he8_pix_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [he8_pkg::PIX_W-1:0] pixel;
  logic                      last;

  modport source (output valid, kind, pixel, last, input ready);
  modport sink   (input valid, kind, pixel, last, output ready);
endinterface

### hw/rtl/he8_res_if.sv
// Result channel carrying one equalized pixel with its frame flags.
// Depends on he8_pkg for the pixel width.
interface he8_res_if;
  logic                      valid;
  logic                      ready;
  logic [he8_pkg::PIX_W-1:0] mapped_pixel;
  logic                      end_of_frame;
  logic                      overflow;

  modport source (output valid, mapped_pixel, end_of_frame, overflow, input ready);
  modport sink   (input valid, mapped_pixel, end_of_frame, overflow, output ready);
endinterface

### hw/rtl/he8_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Standalone; no package dependencies.
module he8_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read and a write to the same entry in one cycle return the old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/histogram_equalization_8bit.sv
// Histogram equalization of 8-bit gray frames. Requests may follow each other every cycle
// while ready, which is low during a table build or a backed-up map output. A map request
// reads the table into the map stage register, then moves on to the output register. The
// last load request starts the table build over all 256 bins, paced by the bin memory read
// and the 8-step restoring divider; no request is accepted until it ends. Reset clears the
// histogram and table via flip-flop valid bits, so requests are accepted right after reset.
module histogram_equalization_8bit (
  input logic         clk_i,
  input logic         rst_ni,
  he8_pix_if.sink     pix_i,
  he8_res_if.source   res_o
);

  `include "histogram_equalization_8bit_assert.svh"

  localparam logic [he8_pkg::CNT_W-1:0] MaxCnt = he8_pkg::CNT_W'(he8_pkg::MAX_PIXELS);
  localparam logic [he8_pkg::PIX_W-1:0] LastBin = he8_pkg::PIX_W'(he8_pkg::BINS - 1);

  typedef enum logic [5:0] {
    S_RUN    = 6'b000001,
    S_BREAD  = 6'b000010,
    S_BACC   = 6'b000100,
    S_BMUL   = 6'b001000,
    S_BDIV   = 6'b010000,
    S_BWRITE = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Handshakes.
  logic in_acc, load_acc, map_acc, clear;

  // Histogram bookkeeping.
  logic [he8_pkg::CNT_W-1:0] total_q, total_d;
  logic                      ovf_q, ovf_d;
  logic [he8_pkg::BINS-1:0]  bvalid_q;

  // Load stage: read data of the bin arrives here.
  logic                      s1_v_q, s1_v_d;
  logic                      s1_inc_q, s1_last_q;
  logic [he8_pkg::PIX_W-1:0] s1_pix_q;

  // Last written bin, for a load that reads the entry written in the same cycle.
  logic                      fwd_v_q, fwd_v_d;
  logic [he8_pkg::PIX_W-1:0] fwd_addr_q;
  logic [he8_pkg::CNT_W-1:0] fwd_data_q;

  // Bin memory ports.
  logic                      bin_we, bin_re;
  logic [he8_pkg::PIX_W-1:0] bin_raddr;
  logic [he8_pkg::CNT_W-1:0] bin_rdata, bin_old, bin_new;

  // Table build.
  logic [he8_pkg::PIX_W-1:0]  k_q, k_d;
  logic [he8_pkg::CNT_W-1:0]  run_q, run_d;
  logic [he8_pkg::REM_W-1:0]  rem_q, rem_d, dvs;
  logic [he8_pkg::PIX_W-1:0]  quo_q, quo_d;
  logic [he8_pkg::STEP_W-1:0] step_q, step_d;
  logic                       tbl_v_q, tbl_v_d;
  logic                       tbl_we;
  logic [he8_pkg::PIX_W-1:0]  tbl_wdata, tbl_rdata;
  logic [he8_pkg::CNT_W-1:0]  acc_cnt;

  // Map stage and output register.
  logic                      m1_v_q, m1_v_d;
  logic                      m1_last_q, m1_ovf_q, m1_tv_q;
  logic                      out_v_q, out_v_d, out_load;
  logic [he8_pkg::PIX_W-1:0] out_pix_q;
  logic                      out_eof_q, out_ovf_q;

  assign out_load    = m1_v_q && (!out_v_q || res_o.ready);
  assign pix_i.ready = (state_q == S_RUN) && !(s1_v_q && s1_last_q) && !(m1_v_q && !out_load);
  assign in_acc      = pix_i.valid && pix_i.ready;
  assign load_acc    = in_acc && !pix_i.kind;
  assign map_acc     = in_acc && pix_i.kind;
  assign clear       = map_acc && pix_i.last;

  // ---------------------------------------------------------------- load pass
  assign bin_re    = load_acc || (state_q == S_BREAD);
  assign bin_raddr = (state_q == S_BREAD) ? k_q : pix_i.pixel;
  assign bin_we    = s1_v_q && s1_inc_q;

  always_comb begin
    if (fwd_v_q && (fwd_addr_q == s1_pix_q)) begin
      bin_old = fwd_data_q;
    end else if (bvalid_q[s1_pix_q]) begin
      bin_old = bin_rdata;
    end else begin
      bin_old = '0;
    end
    bin_new = bin_old + he8_pkg::CNT_W'(1);
  end

  always_comb begin
    total_d = total_q;
    ovf_d   = ovf_q;
    s1_v_d  = load_acc;
    fwd_v_d = fwd_v_q;
    if (load_acc) begin
      if (total_q < MaxCnt) begin
        total_d = total_q + he8_pkg::CNT_W'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (bin_we) begin
      fwd_v_d = 1'b1;
    end
    if (clear) begin
      total_d = '0;
      ovf_d   = 1'b0;
      fwd_v_d = 1'b0;
    end
  end

  he8_ram #(
    .WIDTH(he8_pkg::CNT_W),
    .DEPTH(he8_pkg::BINS)
  ) u_bin_ram (
    .clk_i  (clk_i),
    .we_i   (bin_we),
    .waddr_i(s1_pix_q),
    .wdata_i(bin_new),
    .re_i   (bin_re),
    .raddr_i(bin_raddr),
    .rdata_o(bin_rdata)
  );

  // ---------------------------------------------------------------- table build
  assign dvs       = he8_pkg::REM_W'(total_q) << step_q;
  assign acc_cnt   = bvalid_q[k_q] ? bin_rdata : '0;
  assign tbl_we    = (state_q == S_BWRITE);
  assign tbl_wdata = (total_q == '0) ? '0 : quo_q;

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    run_d   = run_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    step_d  = step_q;
    tbl_v_d = tbl_v_q;
    case (state_q)
      S_RUN: begin
        if (s1_v_q && s1_last_q) begin
          state_d = S_BREAD;
          k_d     = '0;
          run_d   = '0;
        end
      end
      S_BREAD: begin
        state_d = S_BACC;
      end
      S_BACC: begin
        run_d   = run_q + acc_cnt;
        state_d = S_BMUL;
      end
      S_BMUL: begin
        // 255 * run as (run << 8) - run.
        rem_d   = (he8_pkg::REM_W'(run_q) << he8_pkg::PIX_W) - he8_pkg::REM_W'(run_q);
        quo_d   = '0;
        step_d  = he8_pkg::STEP_W'(he8_pkg::PIX_W - 1);
        state_d = S_BDIV;
      end
      S_BDIV: begin
        // One restoring step per cycle, quotient bits from the top down.
        if (rem_q >= dvs) begin
          rem_d = rem_q - dvs;
          quo_d = {quo_q[he8_pkg::PIX_W-2:0], 1'b1};
        end else begin
          quo_d = {quo_q[he8_pkg::PIX_W-2:0], 1'b0};
        end
        step_d = step_q - he8_pkg::STEP_W'(1);
        if (step_q == '0) begin
          state_d = S_BWRITE;
        end
      end
      S_BWRITE: begin
        if (k_q == LastBin) begin
          tbl_v_d = 1'b1;
          state_d = S_RUN;
        end else begin
          k_d     = k_q + he8_pkg::PIX_W'(1);
          state_d = S_BREAD;
        end
      end
      default: begin
        state_d = S_RUN;
      end
    endcase
  end

  he8_ram #(
    .WIDTH(he8_pkg::PIX_W),
    .DEPTH(he8_pkg::BINS)
  ) u_tbl_ram (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(k_q),
    .wdata_i(tbl_wdata),
    .re_i   (map_acc),
    .raddr_i(pix_i.pixel),
    .rdata_o(tbl_rdata)
  );

  // ---------------------------------------------------------------- map pass
  always_comb begin
    m1_v_d = m1_v_q;
    if (map_acc) begin
      m1_v_d = 1'b1;
    end else if (out_load) begin
      m1_v_d = 1'b0;
    end
    out_v_d = out_v_q;
    if (out_load) begin
      out_v_d = 1'b1;
    end else if (res_o.ready) begin
      out_v_d = 1'b0;
    end
  end

  assign res_o.valid        = out_v_q;
  assign res_o.mapped_pixel = out_pix_q;
  assign res_o.end_of_frame = out_eof_q;
  assign res_o.overflow     = out_ovf_q;

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_RUN;
      total_q  <= '0;
      ovf_q    <= 1'b0;
      s1_v_q   <= 1'b0;
      fwd_v_q  <= 1'b0;
      tbl_v_q  <= 1'b0;
      m1_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
      bvalid_q <= '0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      ovf_q   <= ovf_d;
      s1_v_q  <= s1_v_d;
      fwd_v_q <= fwd_v_d;
      tbl_v_q <= tbl_v_d;
      m1_v_q  <= m1_v_d;
      out_v_q <= out_v_d;
      // Clearing wins over a write of an older load in the same cycle.
      if (clear) begin
        bvalid_q <= '0;
      end else if (bin_we) begin
        bvalid_q[s1_pix_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_acc) begin
      s1_pix_q  <= pix_i.pixel;
      s1_last_q <= pix_i.last;
      s1_inc_q  <= (total_q < MaxCnt);
    end
    if (bin_we) begin
      fwd_addr_q <= s1_pix_q;
      fwd_data_q <= bin_new;
    end
    k_q    <= k_d;
    run_q  <= run_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    step_q <= step_d;
    if (map_acc) begin
      m1_last_q <= pix_i.last;
      m1_ovf_q  <= ovf_q;
      m1_tv_q   <= tbl_v_q;
    end
    if (out_load) begin
      out_pix_q <= m1_tv_q ? tbl_rdata : '0;
      out_eof_q <= m1_last_q;
      out_ovf_q <= m1_ovf_q;
    end
  end

  // ---------------------------------------------------------------- checks
  `HE8_ASSERT_ALWAYS(a_no_req_in_build, (state_q != S_RUN) |-> !pix_i.ready, "request in build")
  `HE8_ASSERT(a_total_bound, total_q <= MaxCnt, "pixel total above its limit")
  `HE8_ASSERT(a_build_starts, (s1_v_q && s1_last_q) |=> (state_q == S_BREAD), "no table build")
  `HE8_ASSERT(a_bin_we_in_run, bin_we |-> (state_q == S_RUN), "bin write during table build")
  `HE8_ASSERT(a_clear_done, clear |=> ((total_q == '0) && !ovf_q && (bvalid_q == '0)), "not cleared")

endmodule

### tb/histogram_equalization_8bit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for histogram_equalization_8bit: drives load and map passes
// and checks every equalized pixel against a predictor of the block kept in this file.
// Depends on he8_pkg, the he8_pix_if and he8_res_if interfaces and the block itself.
module histogram_equalization_8bit_test;
  import he8_pkg::*;

  localparam logic KIND_LOAD       = 1'b0;
  localparam logic KIND_MAP        = 1'b1;
  // Long enough to cover one table build with margin.
  localparam int   BUILD_CYCLES    = 3200;
  localparam int   HOLD_OFF_CYCLES = 400;
  localparam int   PHASE_ITEMS     = 160;

  typedef struct packed {
    logic [PIX_W-1:0] mapped_pixel;
    logic             end_of_frame;
    logic             overflow;
  } eq_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  he8_pix_if pix_if ();
  he8_res_if res_if ();

  histogram_equalization_8bit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_if),
    .res_o  (res_if)
  );

  always #2 clk_i = ~clk_i;

  // Predicted state of the block.
  logic [CNT_W-1:0] hist_bins [BINS];
  logic [PIX_W-1:0] eq_lut [BINS];
  logic [CNT_W-1:0] hist_total;
  logic             hist_ovf;

  eq_result_t expected_pixels [$];

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int hold_off_req   = 0;
  int error_count    = 0;
  int results_checked = 0;
  int loads_sent     = 0;
  int maps_sent      = 0;
  int tables_built   = 0;

  function automatic void clear_hist_prediction();
    for (int k = 0; k < BINS; k++) begin
      hist_bins[k] = '0;
    end
    hist_total = '0;
    hist_ovf   = 1'b0;
  endfunction

  function automatic void rebuild_eq_lut();
    longint unsigned running;
    longint unsigned scaled;
    running = 0;
    for (int k = 0; k < BINS; k++) begin
      running += hist_bins[k];
      if (hist_total == '0) begin
        eq_lut[k] = '0;
      end else begin
        scaled = (64'd255 * running) / hist_total;
        if (scaled > 64'd255) begin
          scaled = 64'd255;
        end
        eq_lut[k] = scaled[PIX_W-1:0];
      end
    end
  endfunction

  function automatic void predict_request(input logic kind, input logic [PIX_W-1:0] pix,
                                          input logic last);
    eq_result_t want;
    if (kind == KIND_LOAD) begin
      loads_sent++;
      if (hist_total < MAX_PIXELS) begin
        hist_bins[pix] = hist_bins[pix] + 1'b1;
        hist_total     = hist_total + 1'b1;
      end else begin
        hist_ovf = 1'b1;
      end
      if (last) begin
        rebuild_eq_lut();
        tables_built++;
      end
    end else begin
      maps_sent++;
      want.mapped_pixel = eq_lut[pix];
      want.end_of_frame = last;
      want.overflow     = hist_ovf;
      expected_pixels.push_back(want);
      // The flag goes out with the last pixel before the histogram is dropped.
      if (last) begin
        clear_hist_prediction();
      end
    end
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= 100) begin
      $display("[%0t ns] mismatch: %s", $time, what);
    end
  endtask

  // Entered and left just after a falling edge, so valid is assigned once per step.
  task automatic send_pixel(input logic kind, input logic [PIX_W-1:0] pix, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.kind  <= kind;
    pix_if.pixel <= pix;
    pix_if.last  <= last;
    do @(posedge clk_i); while (pix_if.ready !== 1'b1);
    predict_request(kind, pix, last);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin : sink_ready_drive
    int hold_left;
    if (hold_off_req > 0) begin
      hold_left    = hold_off_req;
      hold_off_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    eq_result_t want;
    if (rst_ni && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("result %0h with no map request pending",
                                  res_if.mapped_pixel));
      end else begin
        want = expected_pixels.pop_front();
        if (res_if.mapped_pixel !== want.mapped_pixel) begin
          report_mismatch($sformatf("mapped_pixel %0d, expected %0d",
                                    res_if.mapped_pixel, want.mapped_pixel));
        end
        if (res_if.end_of_frame !== want.end_of_frame) begin
          report_mismatch($sformatf("end_of_frame %b, expected %b",
                                    res_if.end_of_frame, want.end_of_frame));
        end
        if (res_if.overflow !== want.overflow) begin
          report_mismatch($sformatf("overflow %b, expected %b",
                                    res_if.overflow, want.overflow));
        end
        results_checked++;
      end
    end
  end

  task automatic set_idling(input int src_pct, input int sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  // The table is all zero after reset.
  task automatic test_map_after_reset();
    send_pixel(KIND_MAP, 8'd0, 1'b0);
    send_pixel(KIND_MAP, 8'd255, 1'b0);
    send_pixel(KIND_MAP, 8'd128, 1'b1);
  endtask

  // A frame of one pixel: a step from 0 to 255 at that level.
  task automatic test_single_pixel_frame();
    send_pixel(KIND_LOAD, 8'd77, 1'b1);
    send_pixel(KIND_MAP, 8'd0, 1'b0);
    send_pixel(KIND_MAP, 8'd76, 1'b0);
    send_pixel(KIND_MAP, 8'd77, 1'b0);
    send_pixel(KIND_MAP, 8'd255, 1'b1);
  endtask

  task automatic test_extreme_levels();
    send_pixel(KIND_LOAD, 8'd0, 1'b0);
    send_pixel(KIND_LOAD, 8'd255, 1'b1);
    send_pixel(KIND_MAP, 8'd0, 1'b0);
    send_pixel(KIND_MAP, 8'd254, 1'b0);
    send_pixel(KIND_MAP, 8'd255, 1'b1);
  endtask

  // A second closing load pixel rebuilds from the counts of both load passes.
  task automatic test_accumulated_loads();
    send_pixel(KIND_LOAD, 8'd10, 1'b0);
    send_pixel(KIND_LOAD, 8'd200, 1'b1);
    send_pixel(KIND_LOAD, 8'd10, 1'b1);
    send_pixel(KIND_MAP, 8'd10, 1'b0);
    send_pixel(KIND_MAP, 8'd200, 1'b1);
  endtask

  // With no load since the last map pass ended, the previous table still applies.
  task automatic test_table_kept();
    send_pixel(KIND_MAP, 8'd9, 1'b0);
    send_pixel(KIND_MAP, 8'd10, 1'b0);
    send_pixel(KIND_MAP, 8'd200, 1'b1);
  endtask

  task automatic test_random_frames(input int n_items);
    int sent;
    int n_load;
    int n_map;
    int shape;
    int choice;
    logic [PIX_W-1:0] base;
    logic [PIX_W-1:0] pix;
    sent = 0;
    while (sent < n_items) begin
      choice = $urandom_range(99);
      if (choice < 80) begin
        n_load = ($urandom_range(9) == 0) ? $urandom_range(300, 100) : $urandom_range(24, 1);
        shape  = $urandom_range(3);
        base   = PIX_W'($urandom);
        for (int i = 0; i < n_load; i++) begin
          case (shape)
            0: pix = PIX_W'($urandom);
            1: pix = base + PIX_W'($urandom_range(7));
            2: pix = $urandom_range(1) ? base : ~base;
            default: pix = PIX_W'(($urandom_range(255) * $urandom_range(255)) >> 8);
          endcase
          send_pixel(KIND_LOAD, pix, i == n_load - 1);
        end
        n_map = $urandom_range(30, 1);
        for (int i = 0; i < n_map; i++) begin
          pix = $urandom_range(1) ? PIX_W'($urandom) : base + PIX_W'($urandom_range(7));
          send_pixel(KIND_MAP, pix, i == n_map - 1);
        end
        sent += n_load + n_map;
      end else if (choice < 90) begin
        // Loads that are never closed; the map pass uses the old table and drops them.
        n_load = $urandom_range(10, 1);
        for (int i = 0; i < n_load; i++) begin
          send_pixel(KIND_LOAD, PIX_W'($urandom), 1'b0);
        end
        n_map = $urandom_range(8, 1);
        for (int i = 0; i < n_map; i++) begin
          send_pixel(KIND_MAP, PIX_W'($urandom), i == n_map - 1);
        end
        sent += n_load + n_map;
      end else begin
        n_map = $urandom_range(8, 1);
        for (int i = 0; i < n_map; i++) begin
          send_pixel(1'($urandom_range(1)), PIX_W'($urandom), 1'($urandom_range(1)));
        end
        sent += n_map;
      end
    end
  endtask

  // The output is held off while map requests keep coming, so the block backs up.
  task automatic test_output_hold_off();
    set_idling(0, 10);
    for (int i = 0; i < 16; i++) begin
      send_pixel(KIND_LOAD, PIX_W'($urandom), i == 15);
    end
    // The first map request waits out the table build; the hold-off starts after it.
    send_pixel(KIND_MAP, PIX_W'($urandom), 1'b0);
    hold_off_req = HOLD_OFF_CYCLES;
    for (int i = 0; i < 47; i++) begin
      send_pixel(KIND_MAP, PIX_W'($urandom), i == 46);
    end
  endtask

  initial begin : run_tests
    int waited;
    pix_if.valid = 1'b0;
    pix_if.kind  = KIND_LOAD;
    pix_if.pixel = '0;
    pix_if.last  = 1'b0;
    res_if.ready = 1'b0;
    clear_hist_prediction();
    for (int k = 0; k < BINS; k++) begin
      eq_lut[k] = '0;
    end

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_map_after_reset();
    test_single_pixel_frame();
    test_extreme_levels();
    test_accumulated_loads();
    test_table_kept();

    set_idling(0, 0);
    test_random_frames(PHASE_ITEMS);
    set_idling(60, 0);
    test_random_frames(PHASE_ITEMS);
    set_idling(0, 60);
    test_random_frames(PHASE_ITEMS);
    set_idling(20, 20);
    test_random_frames(PHASE_ITEMS);

    test_output_hold_off();

    pix_if.valid <= 1'b0;
    set_idling(0, 0);
    waited = 0;
    while (expected_pixels.size() != 0 && waited < 100000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (BUILD_CYCLES) @(negedge clk_i);
    if (expected_pixels.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_pixels.size()));
    end

    $display("Sent %0d load and %0d map requests over %0d table builds; %0d results checked.",
             loads_sent, maps_sent, tables_built, results_checked);
    $display("Covered idle and stalling phases, kept and rebuilt tables and an output hold-off.");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
